### rtl/pid_pkg.sv
// Shared types and constants for the trapezoid-integral PID controller.
`timescale 1ns / 1ps

package pid_pkg;

   localparam int unsigned ERR_W      = 17;
   localparam int unsigned GAIN_W     = 32;
   localparam int unsigned LIMIT_W    = 31;
   localparam int unsigned INTEG_W    = 24;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic signed [INTEG_W-1:0] INTEG_LIMIT      = 24'sd1310720;
   localparam logic [LIMIT_W-1:0]        DRIVE_LIMIT_RST  = 31'd65535;
   localparam logic [47:0]               INC_SAT_BOUND    = 48'd167772160;
   localparam logic [22:0]               INC_SAT_MAG      = 23'h400000;
   localparam logic [27:0]               RECIP_FIVE       = 28'd214748365;
   localparam logic signed [56:0]        TRUNC_BIAS       = 57'sd65535;

   typedef enum logic [1:0] {
      CSR_PROP_GAIN   = 2'd0,
      CSR_INTEG_GAIN  = 2'd1,
      CSR_DERIV_GAIN  = 2'd2,
      CSR_DRIVE_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] setpoint;
      logic signed [15:0] measurement;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic signed [15:0] err_now;
      logic signed [15:0] err_prev;
      logic signed [15:0] err_prev2;
   } rsp_type;

endpackage

### rtl/pid_trapezoid_integral_clamped.sv
// PID controller with clamped trapezoid integral, single-pass pipeline.
`timescale 1ns / 1ps

// One sample enters per clock while req_stall is low. The arithmetic
// pipeline has seven register stages: error capture, the three gain
// multiplies, the divide by forty (magnitude and reciprocal multiply), the
// integral accumulate and clamp, the control sum, and the truncation and
// output clamp. The pipeline moves as a whole; req_stall rises only while a
// finished result is held in the output register by rsp_stall. Write the
// gain and limit registers only while no sample is in flight.
module pid_trapezoid_integral_clamped (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pid_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pid_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  pid_pkg::csr_index_type          csr_index,
   input  logic [pid_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic signed [pid_pkg::GAIN_W-1:0]  prop_gain_ff;
   logic signed [pid_pkg::GAIN_W-1:0]  integ_gain_ff;
   logic signed [pid_pkg::GAIN_W-1:0]  deriv_gain_ff;
   logic [pid_pkg::LIMIT_W-1:0]        drive_limit_ff;

   logic signed [pid_pkg::ERR_W-1:0]   hist0_ff;
   logic signed [pid_pkg::ERR_W-1:0]   hist1_ff;
   logic signed [pid_pkg::INTEG_W-1:0] integral_acc_ff;
   logic signed [pid_pkg::INTEG_W-1:0] integral_acc_in;

   logic [5:0] stg_vld_ff;
   logic       rsp_valid_ff;
   logic       pipe_en;
   logic       req_xfer;

   // stage 1
   logic signed [pid_pkg::ERR_W-1:0]   err_in;
   logic signed [pid_pkg::ERR_W-1:0]   s1_e0_ff;
   logic signed [pid_pkg::ERR_W-1:0]   s1_e1_ff;
   logic signed [pid_pkg::ERR_W-1:0]   s1_e2_ff;
   // stage 2
   logic signed [17:0] err_sum;
   logic signed [17:0] err_diff;
   logic signed [48:0] p_prod_in;
   logic signed [49:0] i_prod_in;
   logic signed [49:0] d_prod_in;
   logic signed [48:0] s2_p_prod_ff;
   logic signed [49:0] s2_i_prod_ff;
   logic signed [49:0] s2_d_prod_ff;
   logic [47:0]        s2_e_wrap_ff;
   // stage 3
   logic               i_neg_in;
   logic signed [49:0] i_abs;
   logic [47:0]        i_mag;
   logic               i_sat_in;
   logic [24:0]        i_x_in;
   logic signed [54:0] d20_in;
   logic               s3_i_neg_ff;
   logic               s3_i_sat_ff;
   logic [24:0]        s3_i_x_ff;
   logic signed [48:0] s3_p_prod_ff;
   logic signed [54:0] s3_d20_ff;
   logic [47:0]        s3_e_wrap_ff;
   // stage 4
   logic [52:0]        recip_prod;
   logic [22:0]        inc_mag_in;
   logic signed [55:0] pd_sum_in;
   logic               s4_i_neg_ff;
   logic [22:0]        s4_inc_mag_ff;
   logic signed [55:0] s4_pd_ff;
   logic [47:0]        s4_e_wrap_ff;
   // stage 5
   logic signed [23:0] inc_in;
   logic signed [24:0] acc_sum;
   logic signed [23:0] s5_acc_ff;
   logic signed [55:0] s5_pd_ff;
   logic [47:0]        s5_e_wrap_ff;
   // stage 6
   logic signed [56:0] total_in;
   logic signed [56:0] s6_total_ff;
   logic [47:0]        s6_e_wrap_ff;
   // output stage
   logic signed [56:0] total_adj;
   logic signed [40:0] drv_q;
   logic signed [40:0] lim_pos;
   logic signed [40:0] lim_neg;
   logic signed [40:0] drv_clamp;
   pid_pkg::rsp_type   rsp_data_in;
   pid_pkg::rsp_type   rsp_data_ff;

   assign pipe_en   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;
   assign req_xfer  = req_valid && pipe_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= '0;
         integ_gain_ff   <= '0;
         deriv_gain_ff   <= '0;
         drive_limit_ff  <= pid_pkg::DRIVE_LIMIT_RST;
         hist0_ff        <= '0;
         hist1_ff        <= '0;
         integral_acc_ff <= '0;
         stg_vld_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               pid_pkg::CSR_PROP_GAIN:   prop_gain_ff   <= $signed(csr_wdata);
               pid_pkg::CSR_INTEG_GAIN:  integ_gain_ff  <= $signed(csr_wdata);
               pid_pkg::CSR_DERIV_GAIN:  deriv_gain_ff  <= $signed(csr_wdata);
               pid_pkg::CSR_DRIVE_LIMIT: drive_limit_ff <= csr_wdata[pid_pkg::LIMIT_W-1:0];
            endcase
         end
         if (req_xfer) begin
            hist0_ff <= err_in;
            hist1_ff <= hist0_ff;
         end
         if (pipe_en) begin
            stg_vld_ff   <= {stg_vld_ff[4:0], req_valid};
            rsp_valid_ff <= stg_vld_ff[5];
            if (stg_vld_ff[3]) begin
               integral_acc_ff <= integral_acc_in;
            end
         end
      end
   end

   // stage 1: error capture
   assign err_in = pid_pkg::ERR_W'(req_data.setpoint) - pid_pkg::ERR_W'(req_data.measurement);

   // stage 2: gain multiplies
   assign err_sum   = 18'(s1_e0_ff) + 18'(s1_e1_ff);
   assign err_diff  = 18'(s1_e0_ff) - 18'(s1_e1_ff);
   assign p_prod_in = 49'(prop_gain_ff) * 49'(s1_e0_ff);
   assign i_prod_in = 50'(integ_gain_ff) * 50'(err_sum);
   assign d_prod_in = 50'(deriv_gain_ff) * 50'(err_diff);

   // stage 3: integral magnitude, derivative times sample rate
   assign i_neg_in = s2_i_prod_ff[49];
   assign i_abs    = i_neg_in ? -s2_i_prod_ff : s2_i_prod_ff;
   assign i_mag    = i_abs[47:0];
   assign i_sat_in = i_mag >= pid_pkg::INC_SAT_BOUND;
   assign i_x_in   = i_mag[27:3];
   assign d20_in   = (55'(s2_d_prod_ff) <<< 4) + (55'(s2_d_prod_ff) <<< 2);

   // stage 4: divide by five through reciprocal
   assign recip_prod = 53'(s3_i_x_ff) * 53'(pid_pkg::RECIP_FIVE);
   assign inc_mag_in = s3_i_sat_ff ? pid_pkg::INC_SAT_MAG : recip_prod[52:30];
   assign pd_sum_in  = 56'(s3_p_prod_ff) + 56'(s3_d20_ff);

   // stage 5: accumulate and clamp integral
   assign inc_in  = s4_i_neg_ff ? -$signed({1'b0, s4_inc_mag_ff})
                                :  $signed({1'b0, s4_inc_mag_ff});
   assign acc_sum = 25'(integral_acc_ff) + 25'(inc_in);

   always_comb begin
      priority if (acc_sum > 25'(pid_pkg::INTEG_LIMIT)) begin
         integral_acc_in = pid_pkg::INTEG_LIMIT;
      end else if (acc_sum < -25'(pid_pkg::INTEG_LIMIT)) begin
         integral_acc_in = -pid_pkg::INTEG_LIMIT;
      end else begin
         integral_acc_in = acc_sum[23:0];
      end
   end

   // stage 6: control sum
   assign total_in = 57'(s5_pd_ff) + 57'(s5_acc_ff);

   // output stage: truncate toward zero, saturate
   assign total_adj = s6_total_ff + (s6_total_ff[56] ? pid_pkg::TRUNC_BIAS : 57'sd0);
   assign drv_q     = $signed(total_adj[56:16]);
   assign lim_pos   = $signed({10'b0, drive_limit_ff});
   assign lim_neg   = -lim_pos;

   always_comb begin
      priority if (drv_q > lim_pos) begin
         drv_clamp = lim_pos;
      end else if (drv_q < lim_neg) begin
         drv_clamp = lim_neg;
      end else begin
         drv_clamp = drv_q;
      end
   end

   always_comb begin
      rsp_data_in.drive     = drv_clamp[31:0];
      rsp_data_in.err_now   = s6_e_wrap_ff[47:32];
      rsp_data_in.err_prev  = s6_e_wrap_ff[31:16];
      rsp_data_in.err_prev2 = s6_e_wrap_ff[15:0];
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_e0_ff      <= err_in;
         s1_e1_ff      <= hist0_ff;
         s1_e2_ff      <= hist1_ff;

         s2_p_prod_ff  <= p_prod_in;
         s2_i_prod_ff  <= i_prod_in;
         s2_d_prod_ff  <= d_prod_in;
         s2_e_wrap_ff  <= {s1_e0_ff[15:0], s1_e1_ff[15:0], s1_e2_ff[15:0]};

         s3_i_neg_ff   <= i_neg_in;
         s3_i_sat_ff   <= i_sat_in;
         s3_i_x_ff     <= i_x_in;
         s3_p_prod_ff  <= s2_p_prod_ff;
         s3_d20_ff     <= d20_in;
         s3_e_wrap_ff  <= s2_e_wrap_ff;

         s4_i_neg_ff   <= s3_i_neg_ff;
         s4_inc_mag_ff <= inc_mag_in;
         s4_pd_ff      <= pd_sum_in;
         s4_e_wrap_ff  <= s3_e_wrap_ff;

         s5_acc_ff     <= integral_acc_in;
         s5_pd_ff      <= s4_pd_ff;
         s5_e_wrap_ff  <= s4_e_wrap_ff;

         s6_total_ff   <= total_in;
         s6_e_wrap_ff  <= s5_e_wrap_ff;

         rsp_data_ff   <= rsp_data_in;
      end
   end

`ifndef SYNTH
   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      (integral_acc_ff <= pid_pkg::INTEG_LIMIT) && (integral_acc_ff >= -pid_pkg::INTEG_LIMIT))
      else $error("integral left its clamp range");

   a_drive_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((33'(rsp_data_ff.drive) <= $signed({2'b0, drive_limit_ff}))
                     && (33'(rsp_data_ff.drive) >= -$signed({2'b0, drive_limit_ff}))))
      else $error("drive exceeds limit");

   a_history_tracks: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (hist0_ff == $past(err_in)) && (hist1_ff == $past(hist0_ff)))
      else $error("error history not advanced on transfer");

   a_hold_integral: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(integral_acc_ff) && $stable(stg_vld_ff))
      else $error("pipeline moved while held");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the trapezoid-integral PID controller.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam longint     INTEG_CLAMP = 1310720;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   pid_pkg::req_type        req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   pid_pkg::rsp_type        rsp_data;
   logic                    csr_we = 1'b0;
   pid_pkg::csr_index_type  csr_index = pid_pkg::CSR_PROP_GAIN;
   logic [31:0]             csr_wdata = '0;

   pid_pkg::req_type        sample_q[$];
   pid_pkg::rsp_type        ctrl_out_q[$];

   int unsigned     send_idle_pct = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     hold_requests = 0;
   int unsigned     hold_served = 0;
   int unsigned     hold_left = 0;
   int unsigned     fail_count = 0;
   int unsigned     cycle_count = 0;

   logic signed [31:0] prop_gain_m = '0;
   logic signed [31:0] integ_gain_m = '0;
   logic signed [31:0] deriv_gain_m = '0;
   logic [30:0]        limit_m = pid_pkg::DRIVE_LIMIT_RST;
   longint             err_hist1 = 0;
   longint             err_hist2 = 0;
   longint             integ_acc_m = 0;

   pid_trapezoid_integral_clamped dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pid_pkg::rsp_type compute_drive(input pid_pkg::req_type r);
      longint  sp, ms, e0, e1, e2, acc, sum, drv, lim;
      pid_pkg::rsp_type res;
      sp  = r.setpoint;
      ms  = r.measurement;
      e0  = sp - ms;
      e1  = err_hist1;
      e2  = err_hist2;
      lim = limit_m;
      acc = integ_acc_m + (longint'(integ_gain_m) * (e0 + e1)) / 40;
      if (acc > INTEG_CLAMP) acc = INTEG_CLAMP;
      else if (acc < -INTEG_CLAMP) acc = -INTEG_CLAMP;
      integ_acc_m = acc;
      sum = longint'(prop_gain_m) * e0 + acc + (longint'(deriv_gain_m) * (e0 - e1)) * 20;
      drv = sum / 65536;
      if (drv > lim) drv = lim;
      else if (drv < -lim) drv = -lim;
      err_hist2 = e1;
      err_hist1 = e0;
      res.drive     = drv[31:0];
      res.err_now   = e0[15:0];
      res.err_prev  = e1[15:0];
      res.err_prev2 = e2[15:0];
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) ctrl_out_q.push_back(compute_drive(req_data));
         if (!req_valid || !req_stall) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= sample_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left   <= 0;
         hold_served <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      pid_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (ctrl_out_q.size() == 0) begin
               report_mismatch("transfer with no expected result");
            end else begin
               want = ctrl_out_q.pop_front();
               if (rsp_data.drive !== want.drive)
                  report_mismatch($sformatf("drive got %0d want %0d",
                                            rsp_data.drive, want.drive));
               if (rsp_data.err_now !== want.err_now)
                  report_mismatch($sformatf("err_now got %0d want %0d",
                                            rsp_data.err_now, want.err_now));
               if (rsp_data.err_prev !== want.err_prev)
                  report_mismatch($sformatf("err_prev got %0d want %0d",
                                            rsp_data.err_prev, want.err_prev));
               if (rsp_data.err_prev2 !== want.err_prev2)
                  report_mismatch($sformatf("err_prev2 got %0d want %0d",
                                            rsp_data.err_prev2, want.err_prev2));
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_csr(input pid_pkg::csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         pid_pkg::CSR_PROP_GAIN:   prop_gain_m  = data;
         pid_pkg::CSR_INTEG_GAIN:  integ_gain_m = data;
         pid_pkg::CSR_DERIV_GAIN:  deriv_gain_m = data;
         pid_pkg::CSR_DRIVE_LIMIT: limit_m      = data[30:0];
         default: ;
      endcase
   endtask

   task automatic write_regs(input logic [31:0] kp, ki, kd, lim);
      write_csr(pid_pkg::CSR_PROP_GAIN, kp);
      write_csr(pid_pkg::CSR_INTEG_GAIN, ki);
      write_csr(pid_pkg::CSR_DERIV_GAIN, kd);
      write_csr(pid_pkg::CSR_DRIVE_LIMIT, lim);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_sample(input logic [15:0] sp, input logic [15:0] ms);
      pid_pkg::req_type r;
      r.setpoint    = sp;
      r.measurement = ms;
      sample_q.push_back(r);
   endtask

   task automatic settle();
      while (sample_q.size() != 0 || req_valid || ctrl_out_q.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      logic [31:0] g;
      case ($urandom_range(4))
         0: g = $urandom_range(1048576) - 524288;
         1: g = $urandom_range(131072) - 65536;
         2: begin
            case ($urandom_range(4))
               0: g = 32'h7FFF_FFFF;
               1: g = 32'h8000_0000;
               2: g = 32'h0000_0000;
               3: g = 32'h0000_0001;
               default: g = 32'hFFFF_FFFF;
            endcase
         end
         3: g = $urandom_range(16777216) - 8388608;
         default: g = $urandom;
      endcase
      return g;
   endfunction

   task automatic run_random(input int n, input int unsigned send_pct,
                             input int unsigned stall_pct, input bit pressure);
      logic [31:0] lim;
      logic [15:0] sp, ms;
      case ($urandom_range(5))
         0: lim = 32'd0;
         1: lim = $urandom_range(100, 1);
         2: lim = 32'(pid_pkg::DRIVE_LIMIT_RST);
         3: lim = 32'h7FFF_FFFF;
         4: lim = $urandom_range(1048576);
         default: lim = $urandom;
      endcase
      write_regs(pick_gain(), pick_gain(), pick_gain(), lim);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      if (pressure) hold_requests++;
      sp = 16'($urandom);
      ms = sp;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               sp = 16'(sp + $urandom_range(8) - 4);
               ms = 16'(sp + $urandom_range(64) - 32);
            end
            5, 6, 7: begin
               sp = 16'($urandom);
               ms = 16'($urandom);
            end
            8: begin
               sp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
               ms = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            end
            default: ;
         endcase
         push_sample(sp, ms);
      end
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset gains: errors only, drive stays zero
      push_sample(16'h7FFF, 16'h8000);
      push_sample(16'h8000, 16'h7FFF);
      push_sample(16'h0000, 16'h0000);
      settle();

      write_regs(32'd65536, 32'd131072, 32'd32768, 32'd1000);
      @(negedge clock);
      push_sample(16'h0000, 16'h0000);
      push_sample(16'h7FFF, 16'h8000);
      push_sample(16'h8000, 16'h7FFF);
      push_sample(16'h7FFF, 16'h8000);
      push_sample(16'd100, 16'd90);
      push_sample(16'h8000, 16'h8000);
      push_sample(16'h7FFF, 16'h7FFF);
      push_sample(16'd1000, -16'sd1000);
      settle();

      // limit write carries bit 31, which must be dropped
      write_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      @(negedge clock);
      push_sample(16'h7FFF, 16'h8000);
      push_sample(16'h8000, 16'h7FFF);
      push_sample(16'h0000, 16'h0001);
      push_sample(16'h0001, 16'h0000);
      settle();

      // zero limit forces drive to zero
      write_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      @(negedge clock);
      push_sample(16'd123, -16'sd456);
      push_sample(16'h8000, 16'h7FFF);
      push_sample(16'd5, 16'd5);
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: run_random(100, 0, 0, 1'b0);
            1: run_random(100, 50, 0, 1'b0);
            2: run_random(100, 0, 50, 1'b0);
            default: run_random(100, 23, 23, 1'b0);
         endcase
      end
      run_random(60, 0, 0, 1'b1);

      repeat (20) @(negedge clock);
      if (ctrl_out_q.size() != 0) report_mismatch("expected results never arrived");
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
